### hdl/vsa_pkg.sv
// ---------------------------------------------------------------------------
// vsa_pkg - voice steal allocator shared definitions
// Field widths, action codes and the scan word that travels along the row
// of voice cells.
// ---------------------------------------------------------------------------
`default_nettype none

package vsa_pkg;

   // pool size default and the widest cell index the scan word can carry
   localparam int NUM_VOICES_DEF = 16;
   localparam int CELL_IDX_W     = 6;

   // channel count and the live bits it keeps
   localparam int NUM_CHANNELS = 2;
   localparam int LIVE_W       = 2;
   localparam logic [LIVE_W-1:0] LIVE_KEEP = LIVE_W'((1 << NUM_CHANNELS) - 1);

   // field widths
   localparam int ACT_W  = 3;
   localparam int SLOT_W = 4;
   localparam int SRC_W  = 8;
   localparam int LOUD_W = 24;
   localparam int CNT_W  = 5;

   // stream word widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   // register reset value
   localparam logic [CNT_W-1:0] VOICES_IN_USE_RST = CNT_W'(16);

   // action codes
   localparam logic [ACT_W-1:0] ACT_STEAL     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_UPDATE    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_CHOKE     = 3'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR_ALL = 3'd4;
   localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd5;

   // scan word handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic [ACT_W-1:0]      action;
      logic [SLOT_W-1:0]     slot;
      logic [SRC_W-1:0]      src;
      logic [LIVE_W-1:0]     live;
      logic [LOUD_W-1:0]     loud;
      logic                  have;      // a voice was chosen or addressed
      logic                  done;      // a silent voice ended the search
      logic                  match;     // chosen voice has the request's source
      logic [LOUD_W-1:0]     best_loud;
      logic [CELL_IDX_W-1:0] best_idx;
      logic                  chk;
   } tok_type;

endpackage

`default_nettype wire

### hdl/vsa_cell.sv
// ---------------------------------------------------------------------------
// vsa_cell - one voice of the allocator row
// Holds one voice's state, applies the passing word's action to it and
// hands the updated word on to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module vsa_cell import vsa_pkg::*; #(
   parameter int CELL_IDX = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CNT_W-1:0] use_count,
   input  wire tok_type          tok_in,
   output tok_type               tok_out
);

   localparam logic [31:0]           IDX_L = 32'(CELL_IDX);
   localparam logic [CELL_IDX_W-1:0] IDX_C = CELL_IDX_W'(CELL_IDX);

   logic [LIVE_W-1:0] live_ff, live_in;
   logic [LOUD_W-1:0] loud_ff, loud_in;
   logic              pend_ff, pend_in;
   logic [SRC_W-1:0]  src_ff,  src_in;
   logic              chk_ff,  chk_in;
   tok_type           tok_ff,  tok_in_nxt;

   // voice update and scan step
   always_comb begin
      logic active;
      logic addressed;
      logic same_src;
      logic replace;
      active     = 32'(use_count) > IDX_L;
      addressed  = active && (32'(tok_in.slot) == IDX_L);
      same_src   = (src_ff == tok_in.src);
      replace    = 1'b0;
      live_in    = live_ff;
      loud_in    = loud_ff;
      pend_in    = pend_ff;
      src_in     = src_ff;
      chk_in     = chk_ff;
      tok_in_nxt = tok_in;
      if (tok_in.valid) begin
         unique case (tok_in.action) inside
            ACT_STEAL: begin
               if (active && !tok_in.done) begin
                  if (live_ff == '0) begin
                     tok_in_nxt.done     = 1'b1;
                     tok_in_nxt.have     = 1'b1;
                     tok_in_nxt.best_idx = IDX_C;
                     tok_in_nxt.chk      = chk_ff;
                  end else if (!pend_ff) begin
                     if (!tok_in.have || (!tok_in.match && same_src)) begin
                        replace = 1'b1;
                     end else if ((!tok_in.match || same_src) &&
                                  (loud_ff < tok_in.best_loud)) begin
                        replace = 1'b1;
                     end
                     if (replace) begin
                        tok_in_nxt.have      = 1'b1;
                        tok_in_nxt.best_idx  = IDX_C;
                        tok_in_nxt.match     = same_src;
                        tok_in_nxt.best_loud = loud_ff;
                        tok_in_nxt.chk       = chk_ff;
                     end
                  end
               end
            end
            ACT_UPDATE: begin
               if (addressed) begin
                  live_in         = tok_in.live;
                  loud_in         = tok_in.loud;
                  src_in          = tok_in.src;
                  pend_in         = 1'b0;
                  tok_in_nxt.have = 1'b1;
                  tok_in_nxt.chk  = chk_ff;
               end
            end
            ACT_CHOKE: begin
               if (active && (tok_in.src != '0) && same_src) begin
                  chk_in = 1'b1;
               end
            end
            ACT_CLEAR, ACT_CLEAR_ALL: begin
               if (addressed || (tok_in.action == ACT_CLEAR_ALL)) begin
                  live_in = '0;
                  loud_in = '0;
                  pend_in = 1'b1;
                  src_in  = '0;
                  chk_in  = 1'b0;
               end
               if (addressed) begin
                  tok_in_nxt.have = 1'b1;
               end
            end
            ACT_QUERY: begin
               if (addressed) begin
                  tok_in_nxt.have = 1'b1;
                  tok_in_nxt.chk  = chk_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         loud_ff <= '0;
         pend_ff <= 1'b1;
         src_ff  <= '0;
         chk_ff  <= 1'b0;
      end else begin
         live_ff <= live_in;
         loud_ff <= loud_in;
         pend_ff <= pend_in;
         src_ff  <= src_in;
         chk_ff  <= chk_in;
      end
   end

   // word register towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

### hdl/voice_steal_allocator.sv
// ---------------------------------------------------------------------------
// voice_steal_allocator - voice table and steal choice for a drum sampler
// Row of voice cells scanned by a travelling word, request and result
// streams and a register port for the pool size.
// ---------------------------------------------------------------------------
// Each voice lives in its own cell; a request becomes a word that walks the
// row one cell per clock, so every action (steal, update, choke, clear,
// clear all, query) passes every cell register: the first cell acts at the
// accepting edge, then each further cell in turn; the result is captured in
// the hold register and loaded into the output register once that is free.
// A new request is taken in the cycle after the result has moved to the
// output register, so requests do not overlap.
// voices_in_use is to be written only while no request is in flight;
// the block itself does not enforce this.
`default_nettype none

module voice_steal_allocator import vsa_pkg::*; #(
   parameter int NUM_VOICES = NUM_VOICES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: voice_slot[3:0], source_id[11:4], live_mask[13:12],
   //        loudness[37:14], zero fill[39:38]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: action[2:0]
   input  wire logic [ACT_W-1:0]      req_tuser,
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: voice_index[3:0], found[4], choke_flag[5], zero fill[7:6]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [2:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      voices_ff, voices_in;
   logic [SLOT_W+1:0]     hold_ff, hold_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W+1:0]     rsp_data_ff, rsp_data_in;
   logic                  req_fire;
   logic                  out_free;
   logic                  csr_write;
   logic [SLOT_W-1:0]     res_idx;
   logic                  res_fnd;
   logic                  res_chk;
   tok_type               tok_launch;
   tok_type               tok_chain [NUM_VOICES+1];
   tok_type               tok_exit;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? 32'(voices_ff) : 32'd0;

   always_comb begin
      voices_in = voices_ff;
      if (csr_write && (csr_paddr[2] == 1'b0)) begin
         voices_in = csr_pwdata[CNT_W-1:0];
      end
   end

   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // word launched into the first cell
   always_comb begin
      tok_launch        = '0;
      tok_launch.valid  = req_fire;
      tok_launch.action = req_tuser;
      tok_launch.slot   = req_tdata[3:0];
      tok_launch.src    = req_tdata[11:4];
      tok_launch.live   = req_tdata[13:12] & LIVE_KEEP;
      tok_launch.loud   = req_tdata[37:14];
   end

   assign tok_chain[0] = tok_launch;

   // row of voice cells
   for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
      vsa_cell #(
         .CELL_IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .use_count (voices_ff),
         .tok_in    (tok_chain[i]),
         .tok_out   (tok_chain[i+1])
      );
   end

   assign tok_exit = tok_chain[NUM_VOICES];

   // result from the word leaving the row
   always_comb begin
      res_idx = '0;
      res_fnd = 1'b0;
      res_chk = 1'b0;
      unique case (tok_exit.action) inside
         ACT_STEAL: begin
            if (tok_exit.have) begin
               res_idx = tok_exit.best_idx[SLOT_W-1:0];
               res_fnd = 1'b1;
               res_chk = tok_exit.chk;
            end
         end
         ACT_UPDATE, ACT_CLEAR, ACT_QUERY: begin
            res_idx = tok_exit.slot;
            res_fnd = tok_exit.have;
            res_chk = tok_exit.have && tok_exit.chk;
         end
         ACT_CHOKE: begin
            res_fnd = (tok_exit.src != '0) && (voices_ff != '0);
         end
         ACT_CLEAR_ALL: begin
            res_fnd = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (tok_exit.valid) begin
               hold_in  = {res_chk, res_fnd, res_idx};
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         voices_ff    <= VOICES_IN_USE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         voices_ff    <= voices_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   // checks
   a_exit_in_run : assert property (@(posedge clock) disable iff (reset)
      tok_exit.valid |-> (state_ff == ST_RUN))
      else $error("word left the cell row outside the run state");

   a_fire_runs : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_RUN))
      else $error("accepted request did not start a scan");

   a_hold_drains : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) && out_free |=> rsp_tvalid && (state_ff == ST_IDLE))
      else $error("held result was not moved to the output register");

   a_first_cell_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !tok_chain[0].valid)
      else $error("second word launched while a scan is in flight");

endmodule

`default_nettype wire

### tb/sv/voice_steal_allocator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// voice_steal_allocator_tb - voice table and steal choice test
// Drives request words and pool-size writes into the allocator. A local
// model of the voice table predicts each result word, and a checker
// compares every delivered word with the oldest prediction, field by field.
// ---------------------------------------------------------------------------

module voice_steal_allocator_tb;
   import vsa_pkg::*;

   // register map and the two action codes the block leaves unused
   localparam logic [2:0]       VOICES_IN_USE_ADDR = 3'd0;
   localparam logic [2:0]       SPARE_REG_ADDR     = 3'd4;
   localparam logic [ACT_W-1:0] ACT_SPARE_6        = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_7        = 3'd7;
   localparam int               WATCHDOG_LIMIT     = 5000;

   typedef struct packed {
      logic [SLOT_W-1:0] voice_index;
      logic              found;
      logic              choke_flag;
   } alloc_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata: voice_slot[3:0], source_id[11:4], live_mask[13:12],
   //        loudness[37:14], zero fill[39:38]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // tuser: action[2:0]
   logic [ACT_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata: voice_index[3:0], found[4], choke_flag[5], zero fill[7:6]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [2:0]            csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   voice_steal_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // local copy of the voice table and the pool size
   logic [LIVE_W-1:0] tbl_live    [NUM_VOICES_DEF];
   logic [LOUD_W-1:0] tbl_loud    [NUM_VOICES_DEF];
   logic              tbl_pending [NUM_VOICES_DEF];
   logic [SRC_W-1:0]  tbl_source  [NUM_VOICES_DEF];
   logic              tbl_choked  [NUM_VOICES_DEF];
   logic [CNT_W-1:0]  pool_setting = VOICES_IN_USE_RST;

   alloc_result_type expected_allocs[$];
   alloc_result_type head_alloc;
   int               fail_count   = 0;
   int               tx_idle_pct  = 0;
   int               rx_idle_pct  = 0;
   int               quiet_cycles = 0;

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // table model
   // ---------------------------------------------------------------------
   function automatic int pool_count();
      return (pool_setting < NUM_VOICES_DEF) ? int'(pool_setting) : NUM_VOICES_DEF;
   endfunction

   function automatic void wipe_slot(input int v);
      tbl_live[v]    = '0;
      tbl_loud[v]    = '0;
      tbl_pending[v] = 1'b1;
      tbl_source[v]  = '0;
      tbl_choked[v]  = 1'b0;
   endfunction

   function automatic alloc_result_type apply_voice_action(
      input logic [ACT_W-1:0]  act,
      input logic [SLOT_W-1:0] slot,
      input logic [SRC_W-1:0]  src,
      input logic [LIVE_W-1:0] live,
      input logic [LOUD_W-1:0] loud
   );
      alloc_result_type res;
      int               n;
      int               best;
      logic             have;
      logic             silent_hit;
      n          = pool_count();
      res        = '0;
      best       = 0;
      have       = 1'b0;
      silent_hit = 1'b0;
      case (act)
         ACT_STEAL: begin
            // first silent voice wins; else same source, then lowest loudness
            for (int v = 0; v < NUM_VOICES_DEF; v++) begin
               if (v < n && !silent_hit) begin
                  if (tbl_live[v] == '0) begin
                     best       = v;
                     have       = 1'b1;
                     silent_hit = 1'b1;
                  end else if (!tbl_pending[v]) begin
                     if (!have || (tbl_source[best] != src && tbl_source[v] == src)) begin
                        best = v;
                        have = 1'b1;
                     end else if ((tbl_source[best] != src || tbl_source[v] == src) &&
                                  tbl_loud[v] < tbl_loud[best]) begin
                        best = v;
                     end
                  end
               end
            end
            if (have) begin
               res.voice_index = SLOT_W'(best);
               res.found       = 1'b1;
               res.choke_flag  = tbl_choked[best];
            end
         end
         ACT_UPDATE: begin
            res.voice_index = slot;
            if (int'(slot) < n) begin
               tbl_live[slot]    = live & LIVE_KEEP;
               tbl_loud[slot]    = loud;
               tbl_source[slot]  = src;
               tbl_pending[slot] = 1'b0;
               res.found         = 1'b1;
               res.choke_flag    = tbl_choked[slot];
            end
         end
         ACT_CHOKE: begin
            if (src != '0 && n != 0) begin
               for (int v = 0; v < n; v++)
                  if (tbl_source[v] == src) tbl_choked[v] = 1'b1;
               res.found = 1'b1;
            end
         end
         ACT_CLEAR: begin
            res.voice_index = slot;
            if (int'(slot) < n) begin
               wipe_slot(int'(slot));
               res.found = 1'b1;
            end
         end
         ACT_CLEAR_ALL: begin
            for (int v = 0; v < NUM_VOICES_DEF; v++) wipe_slot(v);
            res.found = 1'b1;
         end
         ACT_QUERY: begin
            res.voice_index = slot;
            if (int'(slot) < n) begin
               res.found      = 1'b1;
               res.choke_flag = tbl_choked[slot];
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // request side: one word per call, called and returning at a falling edge
   // ---------------------------------------------------------------------
   task automatic issue_request(
      input logic [ACT_W-1:0]  act,
      input logic [SLOT_W-1:0] slot,
      input logic [SRC_W-1:0]  src,
      input logic [LIVE_W-1:0] live,
      input logic [LOUD_W-1:0] loud
   );
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) @(negedge clock);
      req_tuser  = act;
      req_tdata  = {2'b00, loud, live, src, slot};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_allocs.push_back(apply_voice_action(act, slot, src, live, loud));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // register write: setup cycle then access cycle
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == VOICES_IN_USE_ADDR) pool_setting = data[CNT_W-1:0];
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // read back the pool size and compare
   task automatic csr_check_pool();
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = VOICES_IN_USE_ADDR;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {27'd0, pool_setting}) begin
         $error("voices_in_use: expected %0d, actual %0d", pool_setting, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // wait until every predicted word has come back
   task automatic drain_results();
      while (expected_allocs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // result side: random back-pressure
   always @(negedge clock) begin
      rsp_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_allocs.size() == 0) begin
            $error("result word %h with no request outstanding", rsp_tdata);
            fail_count++;
         end else begin
            head_alloc = expected_allocs.pop_front();
            if (rsp_tdata[3:0] !== head_alloc.voice_index) begin
               $error("voice_index: expected %0d, actual %0d",
                      head_alloc.voice_index, rsp_tdata[3:0]);
               fail_count++;
            end
            if (rsp_tdata[4] !== head_alloc.found) begin
               $error("found: expected %0d, actual %0d", head_alloc.found, rsp_tdata[4]);
               fail_count++;
            end
            if (rsp_tdata[5] !== head_alloc.choke_flag) begin
               $error("choke_flag: expected %0d, actual %0d",
                      head_alloc.choke_flag, rsp_tdata[5]);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // random field helpers
   function automatic logic [LOUD_W-1:0] random_loudness();
      case ($urandom_range(3))
         0:       return ($urandom_range(1) != 0) ? '1 : '0;
         1:       return LOUD_W'($urandom_range(0, 3));
         default: return LOUD_W'($urandom());
      endcase
   endfunction

   function automatic logic [SRC_W-1:0] random_source();
      return ($urandom_range(3) == 0) ? SRC_W'($urandom()) : SRC_W'($urandom_range(1, 4));
   endfunction

   function automatic logic [LIVE_W-1:0] random_live();
      return ($urandom_range(7) == 0) ? '0 : LIVE_W'($urandom_range(1, 3));
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // every action, field extremes, choke marks, unused codes
   task automatic test_actions();
      tx_idle_pct = 23;
      rx_idle_pct = 83;
      csr_check_pool();
      issue_request(ACT_QUERY,     4'd15, 8'd0,   2'd0, 24'd0);
      issue_request(ACT_STEAL,     4'd0,  8'd0,   2'd0, 24'd0);
      issue_request(ACT_UPDATE,    4'd0,  8'd255, 2'd3, 24'hFFFFFF);
      issue_request(ACT_UPDATE,    4'd15, 8'd0,   2'd1, 24'd0);
      issue_request(ACT_UPDATE,    4'd3,  8'd3,   2'd0, 24'd7);
      issue_request(ACT_STEAL,     4'd0,  8'd255, 2'd0, 24'd0);
      issue_request(ACT_CHOKE,     4'd0,  8'd0,   2'd0, 24'd0);
      issue_request(ACT_CHOKE,     4'd0,  8'd255, 2'd0, 24'd0);
      issue_request(ACT_QUERY,     4'd0,  8'd0,   2'd0, 24'd0);
      issue_request(ACT_UPDATE,    4'd0,  8'd1,   2'd2, 24'd5);
      issue_request(ACT_SPARE_6,   4'd0,  8'd0,   2'd0, 24'd0);
      issue_request(ACT_SPARE_7,   4'd9,  8'd9,   2'd3, 24'hFFFFFF);
      issue_request(ACT_CLEAR,     4'd0,  8'd0,   2'd0, 24'd0);
      issue_request(ACT_QUERY,     4'd0,  8'd0,   2'd0, 24'd0);
      issue_request(ACT_CLEAR_ALL, 4'd0,  8'd0,   2'd0, 24'd0);
      issue_request(ACT_STEAL,     4'd0,  8'd0,   2'd0, 24'd0);
      drain_results();
   endtask

   // empty pool, single voice, oversize setting, spare register
   task automatic test_pool_sizes();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      csr_write(VOICES_IN_USE_ADDR, 32'hFFFF_FFE0);
      csr_check_pool();
      issue_request(ACT_STEAL,     4'd0, 8'd1, 2'd0, 24'd0);
      issue_request(ACT_CHOKE,     4'd0, 8'd5, 2'd0, 24'd0);
      issue_request(ACT_UPDATE,    4'd0, 8'd4, 2'd1, 24'd9);
      issue_request(ACT_QUERY,     4'd7, 8'd0, 2'd0, 24'd0);
      issue_request(ACT_CLEAR,     4'd2, 8'd0, 2'd0, 24'd0);
      issue_request(ACT_CLEAR_ALL, 4'd0, 8'd0, 2'd0, 24'd0);
      drain_results();
      csr_write(VOICES_IN_USE_ADDR, 32'd1);
      csr_check_pool();
      issue_request(ACT_UPDATE, 4'd0, 8'd4, 2'd1, 24'd100);
      issue_request(ACT_STEAL,  4'd0, 8'd9, 2'd0, 24'd0);
      issue_request(ACT_UPDATE, 4'd1, 8'd4, 2'd3, 24'd1);
      issue_request(ACT_CHOKE,  4'd0, 8'd4, 2'd0, 24'd0);
      issue_request(ACT_STEAL,  4'd0, 8'd4, 2'd0, 24'd0);
      drain_results();
      csr_write(VOICES_IN_USE_ADDR, 32'd31);
      csr_check_pool();
      issue_request(ACT_QUERY, 4'd15, 8'd0, 2'd0, 24'd0);
      drain_results();
      // writes to the spare address leave the pool alone
      csr_write(SPARE_REG_ADDR, 32'd3);
      csr_check_pool();
      issue_request(ACT_QUERY, 4'd15, 8'd0, 2'd0, 24'd0);
      drain_results();
   endtask

   // mostly fill-then-steal sequences, the rest random words
   task automatic test_random_mix(input int n_items, input int tx_pct, input int rx_pct);
      int sent;
      int k;
      int kind;
      int n;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      sent        = 0;
      while (sent < n_items) begin
         n = pool_count();
         if ($urandom_range(9) < 6) begin
            // every voice of the pool gets an update, mostly live, so steals reach the comparison
            for (int v = 0; v < n; v++)
               issue_request(ACT_UPDATE, SLOT_W'(v), random_source(), random_live(),
                             random_loudness());
            k = $urandom_range(2, 6);
            repeat (k) begin
               kind = $urandom_range(9);
               if (kind < 7)
                  issue_request(ACT_STEAL, SLOT_W'($urandom()), SRC_W'($urandom_range(0, 5)),
                                LIVE_W'($urandom()), random_loudness());
               else if (kind == 7)
                  issue_request(ACT_CHOKE, SLOT_W'($urandom()), SRC_W'($urandom_range(0, 5)),
                                LIVE_W'($urandom()), random_loudness());
               else if (kind == 8)
                  issue_request(ACT_QUERY, SLOT_W'($urandom()), random_source(),
                                LIVE_W'($urandom()), random_loudness());
               else
                  issue_request(ACT_CLEAR, SLOT_W'($urandom()), random_source(),
                                LIVE_W'($urandom()), random_loudness());
            end
            sent += n + k;
         end else begin
            issue_request(ACT_W'($urandom()), SLOT_W'($urandom()), SRC_W'($urandom()),
                          LIVE_W'($urandom()), LOUD_W'($urandom()));
            sent++;
         end
      end
      drain_results();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int v = 0; v < NUM_VOICES_DEF; v++) wipe_slot(v);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_actions();
      test_pool_sizes();
      csr_write(VOICES_IN_USE_ADDR, 32'd16);
      test_random_mix(280, 23, 83);
      csr_write(VOICES_IN_USE_ADDR, 32'($urandom_range(2, 15)));
      csr_check_pool();
      test_random_mix(280, 83, 23);
      csr_write(VOICES_IN_USE_ADDR, 32'd31);
      test_random_mix(290, 0, 0);

      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
